// ===== rtl/core/vfbb_pkg.sv =====
package vfbb_pkg;

   localparam int COORD_W = 16;
   localparam int CNT_W = 16;
   localparam int CSR_W = 16;
   localparam int AXES = 3;
   localparam int WORD_W = 32;
   localparam int QUEUE_DEPTH_DEF = 8;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [AXES-1:0] vec_type;

   typedef struct packed {
      vec_type lo;
      vec_type hi;
   } box_type;

   typedef struct packed {
      logic    is_total;
      box_type box;
   } result_type;

   // up to two results leave the accumulator per vertex: frame first, total second
   typedef struct packed {
      logic       frame_valid;
      logic       total_valid;
      result_type frame_res;
      result_type total_res;
   } push_type;

   typedef enum logic [1:0] {
      CSR_WIDE_FORMAT     = 2'd0,
      CSR_VERTS_PER_FRAME = 2'd1,
      CSR_FRAME_TOTAL     = 2'd2
   } csr_index_type;

   localparam coord_type POS_LIMIT = 16'sh7fff;
   localparam coord_type NEG_LIMIT = 16'sh8000;
   localparam box_type BOX_RESET = '{lo: {AXES{POS_LIMIT}}, hi: {AXES{NEG_LIMIT}}};

   // 11/11/10 fields moved to the top of a 16-bit coordinate
   function automatic vec_type unpack_word(logic [WORD_W-1:0] w);
      vec_type v;
      v[0] = {w[10:0], 5'b0};
      v[1] = {w[21:11], 5'b0};
      v[2] = {w[31:22], 6'b0};
      return v;
   endfunction

   // (lo + hi) / 2 rounded toward zero
   function automatic coord_type center(coord_type lo, coord_type hi);
      logic [COORD_W:0] sum;
      logic [COORD_W:0] adj;
      sum = {lo[COORD_W-1], lo} + {hi[COORD_W-1], hi};
      adj = sum + {{COORD_W{1'b0}}, sum[COORD_W]};
      return adj[COORD_W:1];
   endfunction

endpackage

// ===== rtl/core/vertex_frame_bounding_box.sv =====
// Axis-aligned bounding box over an animated vertex stream.
//
// Input channel req_*: one vertex per transaction, either a packed 11/11/10 word
// (req_packed_word) or three signed 16-bit coordinates (req_wide_x/y/z), chosen
// by the wide_format register. Result channel rsp_*: after the last vertex of a
// frame one frame result (rsp_is_total = 0); after the last frame a second result
// for the whole animation follows (rsp_is_total = 1). Each carries min, max and
// center per axis.
// Configuration: csr_wr_en writes csr_wdata to the register csr_index selects
// (0 wide_format, 1 verts_per_frame, 2 frame_total); write only while idle.
// With an empty result queue, rsp_valid rises once the vertex transaction that
// ends a frame has passed the unpack register and the queue count register.
// Throughput: one vertex per cycle while req_stall is low, set by the single
// compare-and-update stage; the result queue absorbs the second result at the
// end of an animation. The result queue holds QUEUE_DEPTH entries; req_stall
// rises when the queue, the vertex in flight and one more vertex could exceed
// it, so a stalled rsp side backs up into req_stall. Reset clears the boxes,
// counters, registers (wide_format 0, both counts 1) and empties the queue.
module vertex_frame_bounding_box
   import vfbb_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [WORD_W-1:0]  req_packed_word,
   input  coord_type          req_wide_x,
   input  coord_type          req_wide_y,
   input  coord_type          req_wide_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_is_total,
   output coord_type          rsp_min_x,
   output coord_type          rsp_min_y,
   output coord_type          rsp_min_z,
   output coord_type          rsp_max_x,
   output coord_type          rsp_max_y,
   output coord_type          rsp_max_z,
   output coord_type          rsp_mid_x,
   output coord_type          rsp_mid_y,
   output coord_type          rsp_mid_z,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   logic             wide_format_ff, wide_format_in;
   logic [CNT_W-1:0] verts_ff, verts_in;
   logic [CNT_W-1:0] frames_ff, frames_in;
   logic             accept;
   logic             vert_valid;
   vec_type          vert;
   push_type         push;
   logic [QCNT_W-1:0] q_count;
   logic [QCNT_W:0]  credit;
   result_type       rsp_res;
   vec_type          rsp_mid;

   always_comb begin
      wide_format_in = wide_format_ff;
      verts_in = verts_ff;
      frames_in = frames_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WIDE_FORMAT: wide_format_in = csr_wdata[0];
            CSR_VERTS_PER_FRAME: verts_in = csr_wdata[CNT_W-1:0];
            CSR_FRAME_TOTAL: frames_in = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_format_ff <= 1'b0;
         verts_ff <= CNT_W'(1);
         frames_ff <= CNT_W'(1);
      end else begin
         wide_format_ff <= wide_format_in;
         verts_ff <= verts_in;
         frames_ff <= frames_in;
      end
   end

   // queue entries plus worst case (two results) for the vertex in flight
   assign credit = {1'b0, q_count} + (vert_valid ? (QCNT_W + 1)'(2) : '0);
   assign req_stall = credit > (QCNT_W + 1)'(QUEUE_DEPTH - 2);
   assign accept = req_valid && !req_stall;

   vfbb_unpack u_unpack (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .wide_format (wide_format_ff),
      .packed_word (req_packed_word),
      .wide_x      (req_wide_x),
      .wide_y      (req_wide_y),
      .wide_z      (req_wide_z),
      .vert_valid  (vert_valid),
      .vert        (vert)
   );

   vfbb_accum u_accum (
      .clock           (clock),
      .reset           (reset),
      .vert_valid      (vert_valid),
      .vert            (vert),
      .verts_per_frame (verts_ff),
      .frame_total     (frames_ff),
      .push            (push)
   );

   vfbb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .count        (q_count),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_total (rsp_is_total),
      .rsp_res      (rsp_res),
      .rsp_mid      (rsp_mid)
   );

   assign rsp_min_x = rsp_res.box.lo[0];
   assign rsp_min_y = rsp_res.box.lo[1];
   assign rsp_min_z = rsp_res.box.lo[2];
   assign rsp_max_x = rsp_res.box.hi[0];
   assign rsp_max_y = rsp_res.box.hi[1];
   assign rsp_max_z = rsp_res.box.hi[2];
   assign rsp_mid_x = rsp_mid[0];
   assign rsp_mid_y = rsp_mid[1];
   assign rsp_mid_z = rsp_mid[2];

endmodule

// ===== rtl/core/vfbb_unpack.sv =====
module vfbb_unpack
   import vfbb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                wide_format,
   input  logic [WORD_W-1:0]   packed_word,
   input  coord_type           wide_x,
   input  coord_type           wide_y,
   input  coord_type           wide_z,
   output logic                vert_valid,
   output vec_type             vert
);

   logic    valid_ff;
   logic    valid_in;
   vec_type vert_ff;
   vec_type vert_in;

   always_comb begin
      valid_in = accept;
      if (wide_format) begin
         vert_in[0] = wide_x;
         vert_in[1] = wide_y;
         vert_in[2] = wide_z;
      end else begin
         vert_in = unpack_word(packed_word);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         vert_ff <= vert_in;
      end
   end

   assign vert_valid = valid_ff;
   assign vert = vert_ff;

endmodule

// ===== rtl/core/vfbb_accum.sv =====
module vfbb_accum
   import vfbb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             vert_valid,
   input  vec_type          vert,
   input  logic [CNT_W-1:0] verts_per_frame,
   input  logic [CNT_W-1:0] frame_total,
   output push_type         push
);

   box_type          fbox_ff, fbox_in, fbox_new;
   box_type          tbox_ff, tbox_in, tbox_new;
   logic [CNT_W-1:0] vidx_ff, vidx_in;
   logic [CNT_W-1:0] fidx_ff, fidx_in;
   logic             last_v;
   logic             last_f;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         fbox_new.lo[a] = ($signed(vert[a]) < $signed(fbox_ff.lo[a])) ? vert[a] : fbox_ff.lo[a];
         fbox_new.hi[a] = ($signed(vert[a]) > $signed(fbox_ff.hi[a])) ? vert[a] : fbox_ff.hi[a];
         tbox_new.lo[a] = ($signed(fbox_new.lo[a]) < $signed(tbox_ff.lo[a])) ?
                          fbox_new.lo[a] : tbox_ff.lo[a];
         tbox_new.hi[a] = ($signed(fbox_new.hi[a]) > $signed(tbox_ff.hi[a])) ?
                          fbox_new.hi[a] : tbox_ff.hi[a];
      end
      // a count of zero wraps to the full 65536
      last_v = vidx_ff == (verts_per_frame - CNT_W'(1));
      last_f = fidx_ff == (frame_total - CNT_W'(1));

      push.frame_valid = vert_valid & last_v;
      push.total_valid = vert_valid & last_v & last_f;
      push.frame_res.is_total = 1'b0;
      push.frame_res.box = fbox_new;
      push.total_res.is_total = 1'b1;
      push.total_res.box = tbox_new;

      fbox_in = fbox_ff;
      tbox_in = tbox_ff;
      vidx_in = vidx_ff;
      fidx_in = fidx_ff;
      if (vert_valid) begin
         if (!last_v) begin
            fbox_in = fbox_new;
            vidx_in = vidx_ff + CNT_W'(1);
         end else begin
            fbox_in = BOX_RESET;
            vidx_in = '0;
            if (!last_f) begin
               tbox_in = tbox_new;
               fidx_in = fidx_ff + CNT_W'(1);
            end else begin
               tbox_in = BOX_RESET;
               fidx_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fbox_ff <= BOX_RESET;
         tbox_ff <= BOX_RESET;
         vidx_ff <= '0;
         fidx_ff <= '0;
      end else begin
         fbox_ff <= fbox_in;
         tbox_ff <= tbox_in;
         vidx_ff <= vidx_in;
         fidx_ff <= fidx_in;
      end
   end

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (vert_valid && last_v) |=> (vidx_ff == '0 && fbox_ff == BOX_RESET))
      else $error("frame box not cleared after frame end");

   a_total_after_frame: assert property (@(posedge clock) disable iff (reset)
      (vert_valid && last_v && last_f) |=> (fidx_ff == '0 && tbox_ff == BOX_RESET))
      else $error("total box not cleared after animation end");

endmodule

// ===== rtl/core/vfbb_queue.sv =====
module vfbb_queue
   import vfbb_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int QCNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  push_type          push,
   output logic [QCNT_W-1:0] count,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_is_total,
   output result_type        rsp_res,
   output vec_type           rsp_mid
);

   result_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, wr_ptr_nxt;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QCNT_W-1:0] push_cnt;
   logic              pop;
   result_type        head;

   function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      pop = (count_ff != '0) && !rsp_stall;
      push_cnt = QCNT_W'(push.frame_valid) + QCNT_W'(push.total_valid);
      wr_ptr_nxt = ptr_inc(wr_ptr_ff);
      count_in = count_ff + push_cnt - QCNT_W'(pop);
      wr_ptr_in = wr_ptr_ff;
      if (push.total_valid) begin
         wr_ptr_in = ptr_inc(wr_ptr_nxt);
      end else if (push.frame_valid) begin
         wr_ptr_in = wr_ptr_nxt;
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.frame_valid) begin
         mem_ff[wr_ptr_ff] <= push.frame_res;
      end
      if (push.total_valid) begin
         mem_ff[wr_ptr_nxt] <= push.total_res;
      end
   end

   always_comb begin
      head = mem_ff[rd_ptr_ff];
      for (int a = 0; a < AXES; a++) begin
         rsp_mid[a] = center(head.box.lo[a], head.box.hi[a]);
      end
   end

   assign count = count_ff;
   assign rsp_valid = count_ff != '0;
   assign rsp_is_total = head.is_total;
   assign rsp_res = head;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.frame_valid || push.total_valid) |->
         ({1'b0, count_ff} + {1'b0, push_cnt}) <= (QCNT_W + 1)'(DEPTH))
      else $error("result queue overflow");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule
